// ===== sv/array_list_table_engine_assert.svh =====
// assertion macros shared by the array list table engine modules
// no dependencies; included by the controller and the datapath
`ifndef ARRAY_LIST_TABLE_ENGINE_ASSERT_SVH
`define ARRAY_LIST_TABLE_ENGINE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ALTE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ALTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/alte_pkg.sv =====
// shared types and constants of the array list table engine
// no dependencies; used by alte_dpath, alte_ctrl and the top level
`default_nettype none

package alte_pkg;

   // field widths of the stream transactions
   localparam int CMD_W       = 3;
   localparam int POS_W       = 7;
   localparam int VAL_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int DATA_W      = 32;
   localparam int FOUND_W     = 6;
   localparam int COUNT_W     = 7;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_GET    = 3'd2,
      CMD_LOCATE = 3'd3,
      CMD_PRIOR  = 3'd4,
      CMD_NEXT   = 3'd5
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 2'd0,
      STS_RANGE    = 2'd1,
      STS_FULL     = 2'd2,
      STS_NOTFOUND = 2'd3
   } status_type;

   // kind of work a command needs after its checks
   typedef enum logic [1:0] {
      PATH_NOW  = 2'd0,
      PATH_WALK = 2'd1,
      PATH_READ = 2'd2,
      PATH_SCAN = 2'd3
   } path_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE    = 3'd0,
      S_WALK    = 3'd1,
      S_READ    = 3'd2,
      S_SCAN    = 3'd3,
      S_DRAIN   = 3'd4,
      S_PUBLISH = 3'd5
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // latch a new command
      logic mem_en;     // access the store at the current index
      logic mem_we;     // write the carried word at the current index
      logic step;       // move the index one entry
      logic walk_done;  // last shift cycle, update the count
      logic scan_rd;    // read belongs to a locate scan
      logic capture;    // take a pending compare result
      logic publish;    // load the result register
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      path_type path;   // path of the command at the input
      logic     at_end; // index reached its last entry
      logic     match;  // registered read equals the searched word
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/alte_dpath.sv =====
// datapath of the array list table engine: entry store, count, index walk
// depends on alte_pkg and array_list_table_engine_assert.svh
`default_nettype none
`include "array_list_table_engine_assert.svh"

module alte_dpath #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire alte_pkg::ctl_type                ctl,
   output      alte_pkg::sts_type                sts,
   input  wire logic [alte_pkg::CMD_W-1:0]       req_command,
   input  wire logic [alte_pkg::POS_W-1:0]       req_position,
   input  wire logic [alte_pkg::VAL_W-1:0]       req_value,
   output      logic [alte_pkg::STATUS_W-1:0]    rsp_status,
   output      logic [alte_pkg::DATA_W-1:0]      rsp_data,
   output      logic [alte_pkg::FOUND_W-1:0]     rsp_found_at,
   output      logic [alte_pkg::COUNT_W-1:0]     rsp_count,
   output      logic                             rsp_empty_res
);

   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > alte_pkg::POS_W) ? CW : alte_pkg::POS_W) + 1;

   // entry store, single port, read before write
   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [DATA_WIDTH-1:0] wr_data;

   logic [CW-1:0]         cnt_ff;
   logic [IW-1:0]         idx_ff;
   logic [IW-1:0]         end_ff;
   logic                  up_ff;
   logic                  first_ff;
   logic                  use_data_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   alte_pkg::status_type  status_ff;
   logic [IW-1:0]         found_ff;
   logic [IW-1:0]         rd_idx_ff;
   logic                  cmp_vld_ff;

   logic [alte_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [alte_pkg::DATA_W-1:0]   rsp_data_ff;
   logic [alte_pkg::FOUND_W-1:0]  rsp_found_ff;
   logic [alte_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic                          rsp_empty_ff;

   logic [CMPW-1:0]       pos_w;
   logic [CMPW-1:0]       cnt_w;
   alte_pkg::path_type    path_pre;
   alte_pkg::status_type  status_pre;
   logic [IW-1:0]         idx_pre;
   logic [IW-1:0]         end_pre;
   logic                  up_pre;
   logic                  use_pre;

   // range checks and walk bounds of the command at the input
   always_comb begin
      pos_w      = CMPW'(req_position);
      cnt_w      = CMPW'(cnt_ff);
      path_pre   = alte_pkg::PATH_NOW;
      status_pre = alte_pkg::STS_OK;
      idx_pre    = '0;
      end_pre    = '0;
      up_pre     = 1'b0;
      use_pre    = 1'b0;
      case (req_command)
         alte_pkg::CMD_INSERT: begin
            if (pos_w > cnt_w) begin
               status_pre = alte_pkg::STS_RANGE;
            end else if (cnt_w >= CMPW'(CAPACITY)) begin
               status_pre = alte_pkg::STS_FULL;
            end else begin
               path_pre = alte_pkg::PATH_WALK;
               idx_pre  = IW'(pos_w);
               end_pre  = IW'(cnt_w);
               up_pre   = 1'b1;
            end
         end
         alte_pkg::CMD_DELETE: begin
            if (pos_w >= cnt_w) begin
               status_pre = alte_pkg::STS_RANGE;
            end else begin
               path_pre = alte_pkg::PATH_WALK;
               idx_pre  = IW'(cnt_w - CMPW'(1));
               end_pre  = IW'(pos_w);
            end
         end
         alte_pkg::CMD_GET: begin
            if (pos_w >= cnt_w) begin
               status_pre = alte_pkg::STS_RANGE;
            end else begin
               path_pre = alte_pkg::PATH_READ;
               idx_pre  = IW'(pos_w);
               use_pre  = 1'b1;
            end
         end
         alte_pkg::CMD_LOCATE: begin
            status_pre = alte_pkg::STS_NOTFOUND;
            if (cnt_w != '0) begin
               path_pre = alte_pkg::PATH_SCAN;
               end_pre  = IW'(cnt_w - CMPW'(1));
               up_pre   = 1'b1;
            end
         end
         alte_pkg::CMD_PRIOR: begin
            if (pos_w == '0 || pos_w >= cnt_w) begin
               status_pre = alte_pkg::STS_RANGE;
            end else begin
               path_pre = alte_pkg::PATH_READ;
               idx_pre  = IW'(pos_w - CMPW'(1));
               use_pre  = 1'b1;
            end
         end
         alte_pkg::CMD_NEXT: begin
            if (pos_w + CMPW'(1) >= cnt_w) begin
               status_pre = alte_pkg::STS_RANGE;
            end else begin
               path_pre = alte_pkg::PATH_READ;
               idx_pre  = IW'(pos_w + CMPW'(1));
               use_pre  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // status toward the controller
   assign sts.path   = path_pre;
   assign sts.at_end = (idx_ff == end_ff);
   assign sts.match  = cmp_vld_ff && (rd_data_ff == val_ff);

   // first shift cycle stores the new word, later ones the word just read
   assign wr_data = first_ff ? val_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.mem_en) begin
         if (ctl.mem_we) begin
            mem[idx_ff] <= wr_data;
         end
         rd_data_ff <= mem[idx_ff];
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctl.walk_done) begin
         cnt_ff <= up_ff ? cnt_ff + CW'(1) : cnt_ff - CW'(1);
      end
   end

   // compare pipeline valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= ctl.scan_rd;
      end
   end

   // command context, index walk and locate result
   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      if (ctl.load) begin
         val_ff      <= DATA_WIDTH'(req_value);
         idx_ff      <= idx_pre;
         end_ff      <= end_pre;
         up_ff       <= up_pre;
         use_data_ff <= use_pre;
         first_ff    <= 1'b1;
         status_ff   <= status_pre;
         found_ff    <= '0;
      end else begin
         if (ctl.step) begin
            idx_ff   <= up_ff ? idx_ff + IW'(1) : idx_ff - IW'(1);
            first_ff <= 1'b0;
         end
         if (ctl.capture && sts.match) begin
            status_ff <= alte_pkg::STS_OK;
            found_ff  <= rd_idx_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctl.publish) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= use_data_ff ? alte_pkg::DATA_W'(rd_data_ff) : '0;
         rsp_found_ff  <= alte_pkg::FOUND_W'(found_ff);
         rsp_count_ff  <= alte_pkg::COUNT_W'(cnt_ff);
         rsp_empty_ff  <= (cnt_ff == '0);
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_found_at  = rsp_found_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;

   // checks
   `ALTE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, cnt_ff <= CW'(CAPACITY), "count above capacity")
   `ALTE_ASSERT_NEXT(a_count_moves, clock, reset, ctl.walk_done, cnt_ff != $past(cnt_ff), "shift left count unchanged")
   `ALTE_ASSERT_NEXT(a_match_ok, clock, reset, ctl.capture && sts.match && !ctl.load, status_ff == alte_pkg::STS_OK, "match not recorded")

endmodule

`default_nettype wire

// ===== sv/alte_ctrl.sv =====
// controller of the array list table engine: sequences shifts, reads and scans
// depends on alte_pkg and array_list_table_engine_assert.svh
`default_nettype none
`include "array_list_table_engine_assert.svh"

module alte_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      alte_pkg::ctl_type ctl,
   input  wire alte_pkg::sts_type sts
);

   alte_pkg::state_type state_ff;
   alte_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alte_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == alte_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctl          = '0;
      case (state_ff)
         alte_pkg::S_IDLE: begin
            if (req_tvalid) begin
               ctl.load = 1'b1;
               case (sts.path)
                  alte_pkg::PATH_WALK: state_in = alte_pkg::S_WALK;
                  alte_pkg::PATH_READ: state_in = alte_pkg::S_READ;
                  alte_pkg::PATH_SCAN: state_in = alte_pkg::S_SCAN;
                  default:             state_in = alte_pkg::S_PUBLISH;
               endcase
            end
         end
         alte_pkg::S_WALK: begin
            ctl.mem_en = 1'b1;
            ctl.mem_we = 1'b1;
            if (sts.at_end) begin
               ctl.walk_done = 1'b1;
               state_in      = alte_pkg::S_PUBLISH;
            end else begin
               ctl.step = 1'b1;
            end
         end
         alte_pkg::S_READ: begin
            ctl.mem_en = 1'b1;
            state_in   = alte_pkg::S_PUBLISH;
         end
         alte_pkg::S_SCAN: begin
            ctl.capture = 1'b1;
            if (sts.match) begin
               state_in = alte_pkg::S_PUBLISH;
            end else begin
               ctl.mem_en  = 1'b1;
               ctl.scan_rd = 1'b1;
               if (sts.at_end) begin
                  state_in = alte_pkg::S_DRAIN;
               end else begin
                  ctl.step = 1'b1;
               end
            end
         end
         alte_pkg::S_DRAIN: begin
            // compare of the last entry read
            ctl.capture = 1'b1;
            state_in    = alte_pkg::S_PUBLISH;
         end
         alte_pkg::S_PUBLISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctl.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = alte_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = alte_pkg::S_IDLE;
         end
      endcase
   end

   // checks
   `ALTE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "accepted a second transaction while busy")
   `ALTE_ASSERT_SAME(a_no_write_idle, clock, reset, ctl.mem_we, !req_tready, "store written while open for input")
   `ALTE_ASSERT_NEXT(a_publish_valid, clock, reset, ctl.publish, rsp_tvalid, "result loaded without valid")

endmodule

`default_nettype wire

// ===== sv/array_list_table_engine.sv =====
// Ordered list engine holding up to CAPACITY words in a single-port store with a registered read.
// One command is taken at a time and gives one result. Each command is accepted, does its store
// work and then loads the result register, which waits while an earlier result is not yet taken.
// Get, prior and next read the store once, insert shifts count - position + 1 entries and delete
// count - position entries at one entry per cycle through the store port, and locate reads one
// entry per cycle, comparing each entry read while reading the next, until the first match or
// a compare of the last entry. Errors and unused commands skip the store work. A new command is
// accepted while the previous result still waits. The store needs no clearing after reset.
// depends on alte_pkg, alte_ctrl and alte_dpath
`default_nettype none

module array_list_table_engine #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // position [6:0], value [38:7], zero [39]
   input  wire logic [alte_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // command [2:0]
   input  wire logic [alte_pkg::CMD_W-1:0]          req_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status [1:0], data [33:2], found_at [39:34], count [46:40], empty_res [47]
   output      logic [alte_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   alte_pkg::ctl_type ctl;
   alte_pkg::sts_type sts;

   logic [alte_pkg::STATUS_W-1:0] rsp_status;
   logic [alte_pkg::DATA_W-1:0]   rsp_data;
   logic [alte_pkg::FOUND_W-1:0]  rsp_found_at;
   logic [alte_pkg::COUNT_W-1:0]  rsp_count;
   logic                          rsp_empty_res;

   // sequencer
   alte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl),
      .sts        (sts)
   );

   // store, count and result register
   alte_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .req_command   (req_tuser),
      .req_position  (req_tdata[6:0]),
      .req_value     (req_tdata[38:7]),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_found_at  (rsp_found_at),
      .rsp_count     (rsp_count),
      .rsp_empty_res (rsp_empty_res)
   );

   // result transaction packing
   assign rsp_tdata = {rsp_empty_res, rsp_count, rsp_found_at, rsp_data, rsp_status};

endmodule

`default_nettype wire

// ===== test/array_list_table_engine_tb.sv =====
// self-checking testbench for the array list table engine: directed table, then random traffic
// commands are predicted by a behavioral list model and results compared field by field
// depends on alte_pkg and array_list_table_engine
`timescale 1ns / 1ps

module array_list_table_engine_tb;

   localparam int CAPACITY    = 64;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_WAIT  = 100;

   // command codes the block ignores
   localparam logic [alte_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [alte_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      alte_pkg::status_type                status;
      logic [alte_pkg::DATA_W-1:0]         data;
      logic [alte_pkg::FOUND_W-1:0]        found_at;
      logic [alte_pkg::COUNT_W-1:0]        count;
      logic                                empty_res;
   } list_result_type;

   typedef struct packed {
      logic [alte_pkg::CMD_W-1:0] cmd;
      logic [alte_pkg::POS_W-1:0] pos;
      logic [alte_pkg::VAL_W-1:0] val;
      logic                       fixed;
      list_result_type            want;
   } stim_row_type;

   localparam list_result_type NO_FIXED = '{alte_pkg::STS_OK, 32'h0, 6'd0, 7'd0, 1'b0};

   // directed rows: fixed expectations where obvious, the rest from the list model
   localparam int N_DIRECTED = 26;
   localparam stim_row_type DIRECTED_ROWS [0:N_DIRECTED-1] = '{
      '{alte_pkg::CMD_GET,     7'd0,   32'h0,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd0, 1'b1}},
      '{alte_pkg::CMD_DELETE,  7'd0,   32'h0,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd0, 1'b1}},
      '{alte_pkg::CMD_LOCATE,  7'd0,   32'h0,        1'b1,
        '{alte_pkg::STS_NOTFOUND, 32'h0, 6'd0, 7'd0, 1'b1}},
      '{alte_pkg::CMD_PRIOR,   7'd0,   32'h0,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd0, 1'b1}},
      '{alte_pkg::CMD_NEXT,    7'd0,   32'h0,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd0, 1'b1}},
      '{alte_pkg::CMD_INSERT,  7'd1,   32'h5,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd0, 1'b1}},
      '{alte_pkg::CMD_INSERT,  7'd0,   32'hFFFFFFFF, 1'b1,
        '{alte_pkg::STS_OK,       32'h0, 6'd0, 7'd1, 1'b0}},
      '{alte_pkg::CMD_INSERT,  7'd1,   32'h0,        1'b1,
        '{alte_pkg::STS_OK,       32'h0, 6'd0, 7'd2, 1'b0}},
      '{alte_pkg::CMD_INSERT,  7'd127, 32'h5,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd2, 1'b0}},
      '{alte_pkg::CMD_INSERT,  7'd1,   32'h12345678, 1'b0, NO_FIXED},
      '{alte_pkg::CMD_GET,     7'd0,   32'h0,        1'b0, NO_FIXED},
      '{alte_pkg::CMD_GET,     7'd2,   32'h0,        1'b0, NO_FIXED},
      '{alte_pkg::CMD_GET,     7'd64,  32'h0,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd3, 1'b0}},
      '{alte_pkg::CMD_PRIOR,   7'd1,   32'h0,        1'b0, NO_FIXED},
      '{alte_pkg::CMD_PRIOR,   7'd3,   32'h0,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd3, 1'b0}},
      '{alte_pkg::CMD_NEXT,    7'd0,   32'h0,        1'b0, NO_FIXED},
      '{alte_pkg::CMD_NEXT,    7'd2,   32'h0,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd3, 1'b0}},
      '{alte_pkg::CMD_NEXT,    7'd127, 32'h0,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd3, 1'b0}},
      '{alte_pkg::CMD_LOCATE,  7'd0,   32'h12345678, 1'b0, NO_FIXED},
      '{alte_pkg::CMD_LOCATE,  7'd0,   32'hDEADBEEF, 1'b1,
        '{alte_pkg::STS_NOTFOUND, 32'h0, 6'd0, 7'd3, 1'b0}},
      '{CMD_SPARE_6,           7'd127, 32'hFFFFFFFF, 1'b1,
        '{alte_pkg::STS_OK,       32'h0, 6'd0, 7'd3, 1'b0}},
      '{CMD_SPARE_7,           7'd0,   32'h0,        1'b1,
        '{alte_pkg::STS_OK,       32'h0, 6'd0, 7'd3, 1'b0}},
      '{alte_pkg::CMD_DELETE,  7'd127, 32'h0,        1'b1,
        '{alte_pkg::STS_RANGE,    32'h0, 6'd0, 7'd3, 1'b0}},
      '{alte_pkg::CMD_DELETE,  7'd0,   32'h0,        1'b0, NO_FIXED},
      '{alte_pkg::CMD_DELETE,  7'd1,   32'h0,        1'b0, NO_FIXED},
      '{alte_pkg::CMD_DELETE,  7'd0,   32'h0,        1'b1,
        '{alte_pkg::STS_OK,       32'h0, 6'd0, 7'd0, 1'b1}}
   };

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [alte_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [alte_pkg::CMD_W-1:0]       req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [alte_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // fixed expectation that travels beside the offered transaction
   logic                             req_fixed;
   list_result_type                  req_want;

   // list model state
   logic [alte_pkg::VAL_W-1:0]       list_words [CAPACITY];
   int                               list_len = 0;
   bit                               growing = 1'b1;

   list_result_type                  expected_q [$];
   int                               fail_count = 0;
   int                               result_idx = 0;
   int                               tx_idle_pct = 0;
   int                               rx_idle_pct = 0;
   bit                               hold_req = 1'b0;
   int                               stall_cycles = 0;

   array_list_table_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // list model: applies one command and gives the result it produces
   function automatic list_result_type apply_command(
         input logic [alte_pkg::CMD_W-1:0] cmd,
         input logic [alte_pkg::POS_W-1:0] pos,
         input logic [alte_pkg::VAL_W-1:0] val);
      list_result_type r;
      int              i;
      bit              hit;
      r = NO_FIXED;
      hit = 1'b0;
      case (cmd)
         alte_pkg::CMD_INSERT: begin
            if (int'(pos) > list_len) r.status = alte_pkg::STS_RANGE;
            else if (list_len >= CAPACITY) r.status = alte_pkg::STS_FULL;
            else begin
               for (i = list_len; i > int'(pos); i--) list_words[i] = list_words[i-1];
               list_words[pos] = val;
               list_len++;
            end
         end
         alte_pkg::CMD_DELETE: begin
            if (int'(pos) >= list_len) r.status = alte_pkg::STS_RANGE;
            else begin
               for (i = int'(pos); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         alte_pkg::CMD_GET: begin
            if (int'(pos) >= list_len) r.status = alte_pkg::STS_RANGE;
            else r.data = list_words[pos];
         end
         alte_pkg::CMD_LOCATE: begin
            r.status = alte_pkg::STS_NOTFOUND;
            for (i = 0; i < list_len; i++) begin
               if (!hit && list_words[i] == val) begin
                  hit = 1'b1;
                  r.status = alte_pkg::STS_OK;
                  r.found_at = i[alte_pkg::FOUND_W-1:0];
               end
            end
         end
         alte_pkg::CMD_PRIOR: begin
            if (pos == 0 || int'(pos) >= list_len) r.status = alte_pkg::STS_RANGE;
            else r.data = list_words[pos-1];
         end
         alte_pkg::CMD_NEXT: begin
            if (int'(pos) + 1 >= list_len) r.status = alte_pkg::STS_RANGE;
            else r.data = list_words[int'(pos)+1];
         end
         default: ;
      endcase
      r.count = list_len[alte_pkg::COUNT_W-1:0];
      r.empty_res = (list_len == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [47:0] got_v,
                                  input logic [47:0] want_v);
      $display("mismatch on result %0d: %s got %h expected %h",
               result_idx, field, got_v, want_v);
      fail_count++;
   endtask

   // offers one transaction at the falling edge and waits until it is taken
   task automatic send_item(input logic [alte_pkg::CMD_W-1:0] cmd,
                            input logic [alte_pkg::POS_W-1:0] pos,
                            input logic [alte_pkg::VAL_W-1:0] val, input logic fixed,
                            input list_result_type want);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, val, pos};
      req_tuser  <= cmd;
      req_fixed  <= fixed;
      req_want   <= want;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // random commands: alternate filling and draining so full and empty lists are reached
   task automatic run_random(input int n_items);
      int                         done_items;
      int                         n;
      int                         roll;
      logic [alte_pkg::CMD_W-1:0] cmd;
      logic [alte_pkg::POS_W-1:0] pos;
      logic [alte_pkg::VAL_W-1:0] val;
      done_items = 0;
      while (done_items < n_items) begin
         n = list_len;
         if (growing && n >= CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
         else if (!growing && n == 0 && $urandom_range(3) == 0) growing = 1'b1;
         else if ($urandom_range(199) == 0) growing = !growing;

         roll = $urandom_range(99);
         if (roll < 2) cmd = (roll == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
         else if (roll < (growing ? 50 : 14)) cmd = alte_pkg::CMD_INSERT;
         else if (roll < (growing ? 60 : 55)) cmd = alte_pkg::CMD_DELETE;
         else if (roll < 72) cmd = alte_pkg::CMD_GET;
         else if (roll < 86) cmd = alte_pkg::CMD_LOCATE;
         else if (roll < 93) cmd = alte_pkg::CMD_PRIOR;
         else cmd = alte_pkg::CMD_NEXT;

         // mostly legal positions, some anywhere in the field
         if ($urandom_range(99) < 12) pos = 7'($urandom_range(127));
         else begin
            case (cmd)
               alte_pkg::CMD_INSERT: pos = 7'($urandom_range(n));
               alte_pkg::CMD_DELETE, alte_pkg::CMD_GET:
                  pos = (n > 0) ? 7'($urandom_range(n - 1)) : 7'd0;
               alte_pkg::CMD_PRIOR: pos = (n > 1) ? 7'($urandom_range(n - 1, 1)) : 7'd1;
               alte_pkg::CMD_NEXT: pos = (n > 1) ? 7'($urandom_range(n - 2)) : 7'd0;
               default: pos = 7'($urandom_range(127));
            endcase
         end

         // values: held words for locate, a small pool for duplicates, extremes
         roll = $urandom_range(99);
         if (cmd == alte_pkg::CMD_LOCATE && n > 0 && roll < 60)
            val = list_words[$urandom_range(n - 1)];
         else if (roll < 75) val = $urandom;
         else if (roll < 85) val = 32'($urandom_range(7));
         else if (roll < 92) val = '1;
         else val = '0;

         send_item(cmd, pos, val, 1'b0, NO_FIXED);
         if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) done_items++;
      end
   endtask

   // result receiver: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // monitor: predict on each accepted command, check each accepted result
   always @(posedge clock) begin : monitor
      list_result_type want;
      list_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = apply_command(req_tuser, req_tdata[alte_pkg::POS_W-1:0],
                                 req_tdata[alte_pkg::POS_W+alte_pkg::VAL_W-1:alte_pkg::POS_W]);
            if (req_fixed) want = req_want;
            expected_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {alte_pkg::status_type'(rsp_tdata[1:0]), rsp_tdata[33:2], rsp_tdata[39:34],
                   rsp_tdata[46:40], rsp_tdata[47]};
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, '0);
            end else begin
               want = expected_q.pop_front();
               if (got.status !== want.status) report_mismatch("status", got.status, want.status);
               if (got.data !== want.data) report_mismatch("data", got.data, want.data);
               if (got.found_at !== want.found_at)
                  report_mismatch("found_at", got.found_at, want.found_at);
               if (got.count !== want.count) report_mismatch("count", got.count, want.count);
               if (got.empty_res !== want.empty_res)
                  report_mismatch("empty_res", got.empty_res, want.empty_res);
            end
            result_idx++;
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin : stimulus
      int i;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_fixed  = 1'b0;
      req_want   = NO_FIXED;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      tx_idle_pct = 8;
      rx_idle_pct = 74;
      for (i = 0; i < N_DIRECTED; i++)
         send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].pos, DIRECTED_ROWS[i].val,
                   DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
      run_random(430);

      // roles swapped
      tx_idle_pct = 74;
      rx_idle_pct = 8;
      run_random(430);

      // no idling, with one long receiver hold-off to back up the input
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_req = 1'b1;
      run_random(440);
      req_tvalid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_q.size() != 0) report_mismatch("missing result", '0, '0);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== array_list_table_engine.f =====
+incdir+sv
sv/alte_pkg.sv
sv/alte_dpath.sv
sv/alte_ctrl.sv
sv/array_list_table_engine.sv
test/array_list_table_engine_tb.sv
